// ===== design/nco_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nco_pkg
// Shared types, constants and the quadrature lookup table of the oscillator.
// ----------------------------------------------------------------------------
package nco_pkg;

	localparam int PHASE_W   = 24;
	localparam int SAMPLE_W  = 16;
	localparam int INDEX_W   = 8;
	localparam int FRAC_W    = 8;
	localparam int PADDR_W   = 2;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [PADDR_W-1:0] REG_PHASE_INCREMENT = 2'd0;
	localparam logic OP_ADVANCE = 1'b0;
	localparam logic OP_LOAD    = 1'b1;

	typedef struct packed {
		logic               operation;
		logic [PHASE_W-1:0] phase_value;
	} nco_in_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] neg_sine_out;
		logic signed [SAMPLE_W-1:0] cosine_out;
	} nco_out_t;

	// index and fraction handed from the phase front end to the table back end
	typedef struct packed {
		logic [INDEX_W-1:0] entry;
		logic [FRAC_W-1:0]  frac;
	} nco_phase_t;

	typedef logic signed [SAMPLE_W-1:0] sample_t;

	// cosine column, entries 0..256; entry 256 repeats entry 0
	function automatic sample_t cos_rom(input logic [INDEX_W:0] idx);
		sample_t c;
		c = '0;
		case (idx)
			9'd0: c = 30000; 9'd1: c = 29990; 9'd2: c = 29963; 9'd3: c = 29918;
			9'd4: c = 29855; 9'd5: c = 29774; 9'd6: c = 29675; 9'd7: c = 29558;
			9'd8: c = 29423; 9'd9: c = 29271; 9'd10: c = 29100; 9'd11: c = 28913;
			9'd12: c = 28708; 9'd13: c = 28485; 9'd14: c = 28246; 9'd15: c = 27989;
			9'd16: c = 27716; 9'd17: c = 27426; 9'd18: c = 27119; 9'd19: c = 26796;
			9'd20: c = 26457; 9'd21: c = 26102; 9'd22: c = 25731; 9'd23: c = 25345;
			9'd24: c = 24944; 9'd25: c = 24527; 9'd26: c = 24096; 9'd27: c = 23650;
			9'd28: c = 23190; 9'd29: c = 22716; 9'd30: c = 22228; 9'd31: c = 21727;
			9'd32: c = 21213; 9'd33: c = 20686; 9'd34: c = 20146; 9'd35: c = 19595;
			9'd36: c = 19031; 9'd37: c = 18456; 9'd38: c = 17870; 9'd39: c = 17274;
			9'd40: c = 16667; 9'd41: c = 16049; 9'd42: c = 15423; 9'd43: c = 14786;
			9'd44: c = 14141; 9'd45: c = 13488; 9'd46: c = 12826; 9'd47: c = 12157;
			9'd48: c = 11480; 9'd49: c = 10796; 9'd50: c = 10106; 9'd51: c = 9410;
			9'd52: c = 8708; 9'd53: c = 8001; 9'd54: c = 7289; 9'd55: c = 6573;
			9'd56: c = 5852; 9'd57: c = 5128; 9'd58: c = 4401; 9'd59: c = 3672;
			9'd60: c = 2940; 9'd61: c = 2206; 9'd62: c = 1472; 9'd63: c = 736;
			9'd64: c = 0; 9'd65: c = -736; 9'd66: c = -1472; 9'd67: c = -2206;
			9'd68: c = -2940; 9'd69: c = -3672; 9'd70: c = -4401; 9'd71: c = -5128;
			9'd72: c = -5852; 9'd73: c = -6573; 9'd74: c = -7289; 9'd75: c = -8001;
			9'd76: c = -8708; 9'd77: c = -9410; 9'd78: c = -10106; 9'd79: c = -10796;
			9'd80: c = -11480; 9'd81: c = -12157; 9'd82: c = -12826; 9'd83: c = -13488;
			9'd84: c = -14141; 9'd85: c = -14786; 9'd86: c = -15423; 9'd87: c = -16049;
			9'd88: c = -16667; 9'd89: c = -17274; 9'd90: c = -17870; 9'd91: c = -18456;
			9'd92: c = -19031; 9'd93: c = -19595; 9'd94: c = -20146; 9'd95: c = -20686;
			9'd96: c = -21213; 9'd97: c = -21727; 9'd98: c = -22228; 9'd99: c = -22716;
			9'd100: c = -23190; 9'd101: c = -23650; 9'd102: c = -24096; 9'd103: c = -24527;
			9'd104: c = -24944; 9'd105: c = -25345; 9'd106: c = -25731; 9'd107: c = -26102;
			9'd108: c = -26457; 9'd109: c = -26796; 9'd110: c = -27119; 9'd111: c = -27426;
			9'd112: c = -27716; 9'd113: c = -27989; 9'd114: c = -28246; 9'd115: c = -28485;
			9'd116: c = -28708; 9'd117: c = -28913; 9'd118: c = -29100; 9'd119: c = -29271;
			9'd120: c = -29423; 9'd121: c = -29558; 9'd122: c = -29675; 9'd123: c = -29774;
			9'd124: c = -29855; 9'd125: c = -29918; 9'd126: c = -29963; 9'd127: c = -29990;
			9'd128: c = -29999; 9'd129: c = -29990; 9'd130: c = -29963; 9'd131: c = -29918;
			9'd132: c = -29855; 9'd133: c = -29774; 9'd134: c = -29675; 9'd135: c = -29558;
			9'd136: c = -29423; 9'd137: c = -29271; 9'd138: c = -29100; 9'd139: c = -28913;
			9'd140: c = -28708; 9'd141: c = -28485; 9'd142: c = -28246; 9'd143: c = -27989;
			9'd144: c = -27716; 9'd145: c = -27426; 9'd146: c = -27119; 9'd147: c = -26796;
			9'd148: c = -26457; 9'd149: c = -26102; 9'd150: c = -25731; 9'd151: c = -25345;
			9'd152: c = -24944; 9'd153: c = -24527; 9'd154: c = -24096; 9'd155: c = -23650;
			9'd156: c = -23190; 9'd157: c = -22716; 9'd158: c = -22228; 9'd159: c = -21727;
			9'd160: c = -21213; 9'd161: c = -20686; 9'd162: c = -20146; 9'd163: c = -19595;
			9'd164: c = -19031; 9'd165: c = -18456; 9'd166: c = -17870; 9'd167: c = -17274;
			9'd168: c = -16667; 9'd169: c = -16049; 9'd170: c = -15423; 9'd171: c = -14786;
			9'd172: c = -14141; 9'd173: c = -13488; 9'd174: c = -12826; 9'd175: c = -12157;
			9'd176: c = -11480; 9'd177: c = -10796; 9'd178: c = -10106; 9'd179: c = -9410;
			9'd180: c = -8708; 9'd181: c = -8001; 9'd182: c = -7289; 9'd183: c = -6573;
			9'd184: c = -5852; 9'd185: c = -5128; 9'd186: c = -4401; 9'd187: c = -3672;
			9'd188: c = -2940; 9'd189: c = -2206; 9'd190: c = -1472; 9'd191: c = -736;
			9'd192: c = 0; 9'd193: c = 736; 9'd194: c = 1472; 9'd195: c = 2206;
			9'd196: c = 2940; 9'd197: c = 3672; 9'd198: c = 4401; 9'd199: c = 5128;
			9'd200: c = 5852; 9'd201: c = 6573; 9'd202: c = 7289; 9'd203: c = 8001;
			9'd204: c = 8708; 9'd205: c = 9410; 9'd206: c = 10106; 9'd207: c = 10796;
			9'd208: c = 11480; 9'd209: c = 12157; 9'd210: c = 12826; 9'd211: c = 13488;
			9'd212: c = 14141; 9'd213: c = 14786; 9'd214: c = 15423; 9'd215: c = 16049;
			9'd216: c = 16667; 9'd217: c = 17274; 9'd218: c = 17870; 9'd219: c = 18456;
			9'd220: c = 19031; 9'd221: c = 19595; 9'd222: c = 20146; 9'd223: c = 20686;
			9'd224: c = 21213; 9'd225: c = 21727; 9'd226: c = 22228; 9'd227: c = 22716;
			9'd228: c = 23190; 9'd229: c = 23650; 9'd230: c = 24096; 9'd231: c = 24527;
			9'd232: c = 24944; 9'd233: c = 25345; 9'd234: c = 25731; 9'd235: c = 26102;
			9'd236: c = 26457; 9'd237: c = 26796; 9'd238: c = 27119; 9'd239: c = 27426;
			9'd240: c = 27716; 9'd241: c = 27989; 9'd242: c = 28246; 9'd243: c = 28485;
			9'd244: c = 28708; 9'd245: c = 28913; 9'd246: c = 29100; 9'd247: c = 29271;
			9'd248: c = 29423; 9'd249: c = 29558; 9'd250: c = 29675; 9'd251: c = 29774;
			9'd252: c = 29855; 9'd253: c = 29918; 9'd254: c = 29963; 9'd255: c = 29990;
			9'd256: c = 30000;
			default: c = '0;
		endcase
		return c;
	endfunction

	// negated sine is the cosine a quarter turn (64 entries) on, modulo 256;
	// the peak at entry 192 is 29999 where the cosine column holds 30000
	function automatic sample_t nsin_rom(input logic [INDEX_W:0] idx);
		logic [INDEX_W-1:0] k;
		sample_t v;
		k = idx[INDEX_W-1:0] + 8'd64;
		v = cos_rom({1'b0, k});
		if (idx[INDEX_W-1:0] == 8'd192)
			v = 16'sd29999;
		return v;
	endfunction

endpackage

// ===== design/nco_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nco_front
// Phase accumulator: loads and advances the phase once per accepted item and
// pushes table index and fraction into the queue.
// ----------------------------------------------------------------------------
module nco_front (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  nco_pkg::nco_in_t        in_data,
	input  logic [nco_pkg::PHASE_W-1:0] phase_increment,
	input  logic                    q_full,
	output logic                    q_push,
	output nco_pkg::nco_phase_t     q_data
);
	import nco_pkg::*;

	logic [PHASE_W-1:0] acc_q;
	logic [PHASE_W-1:0] base;
	logic [PHASE_W-1:0] next_acc;

	assign in_stall = q_full;
	assign q_push   = in_valid & ~q_full;
	assign base     = (in_data.operation == OP_LOAD) ? in_data.phase_value : acc_q;
	assign next_acc = base + phase_increment;
	assign q_data.entry = next_acc[PHASE_W-1 -: INDEX_W];
	assign q_data.frac  = next_acc[PHASE_W-INDEX_W-1 -: FRAC_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (q_push) begin
			acc_q <= next_acc;
		end
	end

endmodule

// ===== design/nco_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nco_queue
// Short FIFO decoupling the phase front end from the interpolation back end.
// ----------------------------------------------------------------------------
module nco_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  nco_pkg::nco_phase_t push_data,
	output logic                full,
	input  logic                pop,
	output logic                not_empty,
	output nco_pkg::nco_phase_t pop_data
);
	import nco_pkg::*;

	localparam int PTR_W = $clog2(QUEUE_DEPTH);

	nco_phase_t       mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_q;
	logic [PTR_W-1:0] rd_q;
	logic [PTR_W:0]   count_q;

	assign full      = (count_q == (PTR_W+1)'(QUEUE_DEPTH));
	assign not_empty = (count_q != '0);
	assign pop_data  = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PTR_W'(QUEUE_DEPTH-1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == PTR_W'(QUEUE_DEPTH-1)) ? '0 : rd_q + 1'b1;
			end
			count_q <= count_q + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) full |-> !push)
		else $error("queue push while full");
	assert property (@(posedge clk) disable iff (!arst_n) !not_empty |-> !pop)
		else $error("queue pop while empty");
	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (PTR_W+1)'(QUEUE_DEPTH))
		else $error("queue count overrun");

endmodule

// ===== design/nco_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nco_back
// Table lookup, then linear interpolation of both columns, then output register.
// ----------------------------------------------------------------------------
module nco_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                q_not_empty,
	input  nco_pkg::nco_phase_t q_data,
	output logic                q_pop,
	output logic                out_valid,
	input  logic                out_stall,
	output nco_pkg::nco_out_t   out_data
);
	import nco_pkg::*;

	localparam int DIFF_W = SAMPLE_W + 1;
	localparam int PROD_W = DIFF_W + FRAC_W + 1;

	// stage 1: table values and fraction
	logic                    v_s1;
	sample_t                 c1_s1, c2_s1, s1_s1, s2_s1;
	logic [FRAC_W-1:0]       f_s1;
	// stage 2: result register
	logic                    v_s2;
	nco_out_t                res_s2;

	logic adv_s2, adv_s1;
	logic signed [DIFF_W-1:0] dc, ds;
	logic signed [PROD_W-1:0] pc, ps;
	logic [INDEX_W:0] e0, e1;

	assign adv_s2 = ~v_s2 | ~out_stall;
	assign adv_s1 = ~v_s1 | adv_s2;
	assign q_pop  = q_not_empty & adv_s1;

	assign e0 = {1'b0, q_data.entry};
	assign e1 = e0 + 1'b1;

	// floor shift of the signed product gives the rounding toward minus infinity
	assign dc = DIFF_W'(c2_s1) - DIFF_W'(c1_s1);
	assign ds = DIFF_W'(s2_s1) - DIFF_W'(s1_s1);
	assign pc = $signed({1'b0, f_s1}) * dc;
	assign ps = $signed({1'b0, f_s1}) * ds;

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			c1_s1 <= cos_rom(e0);
			c2_s1 <= cos_rom(e1);
			s1_s1 <= nsin_rom(e0);
			s2_s1 <= nsin_rom(e1);
			f_s1  <= q_data.frac;
		end
		if (adv_s2 && v_s1) begin
			res_s2.cosine_out   <= c1_s1 + SAMPLE_W'(pc >>> FRAC_W);
			res_s2.neg_sine_out <= s1_s1 + SAMPLE_W'(ps >>> FRAC_W);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (adv_s1) v_s1 <= q_not_empty;
			if (adv_s2) v_s2 <= v_s1;
		end
	end

	assign out_valid = v_s2;
	assign out_data  = res_s2;

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("stalled result changed");
	assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && !adv_s1 |=> v_s1)
		else $error("stage one item lost");

endmodule

// ===== design/nco_interpolated_sincos.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nco_interpolated_sincos
// Phase accumulator oscillator with interpolated quadrature table output.
// ----------------------------------------------------------------------------
// Path: an accepted item enters the queue, then the table stage, then the
// interpolation register. Throughput, while out_stall stays low:
// one item per cycle; the phase accumulator add is the only loop.
// Reset: accumulator, increment register, queue and stage valids clear.
// ----------------------------------------------------------------------------
module nco_interpolated_sincos (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [nco_pkg::PADDR_W-1:0]         paddr,
	input  logic [31:0]                         pwdata,
	output logic [31:0]                         prdata,
	output logic                                pready,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  nco_pkg::nco_in_t                    in_data,
	output logic                                out_valid,
	input  logic                                out_stall,
	output nco_pkg::nco_out_t                   out_data
);
	import nco_pkg::*;

	logic [PHASE_W-1:0] inc_q;
	logic       q_full, q_push, q_pop, q_ne;
	nco_phase_t q_wdata, q_rdata;

	assign pready = 1'b1;
	assign prdata = (paddr == REG_PHASE_INCREMENT) ? {8'd0, inc_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inc_q <= '0;
		end else if (psel && penable && pwrite && paddr == REG_PHASE_INCREMENT) begin
			inc_q <= pwdata[PHASE_W-1:0];
		end
	end

	nco_front u_front (
		.clk, .arst_n, .in_valid, .in_stall, .in_data,
		.phase_increment(inc_q), .q_full, .q_push, .q_data(q_wdata)
	);

	nco_queue u_queue (
		.clk, .arst_n, .push(q_push), .push_data(q_wdata), .full(q_full),
		.pop(q_pop), .not_empty(q_ne), .pop_data(q_rdata)
	);

	nco_back u_back (
		.clk, .arst_n, .q_not_empty(q_ne), .q_data(q_rdata), .q_pop,
		.out_valid, .out_stall, .out_data
	);

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives ticks into the interpolating oscillator under changing phase steps and
// random idling on both sides, predicts each sample from the phase and a table
// of its own, and checks every result in order.
// ----------------------------------------------------------------------------
import nco_pkg::*;

class sample_board;
	logic [PHASE_W-1:0] acc;
	logic [PHASE_W-1:0] step;
	nco_out_t pending[$];
	int errors;

	function new();
		acc = '0;
		step = '0;
		errors = 0;
	endfunction

	// negated sine from the cosine column a quarter turn on; the peak at
	// entry 192 is 29999
	function int nsin_at(int idx, ref int tab[257]);
		if (idx % 256 == 192)
			return 29999;
		return tab[(idx + 64) % 256];
	endfunction

	function void note_tick(nco_in_t it, ref int tab[257]);
		int e, f, c1, c2, s1, s2;
		nco_out_t r;
		if (it.operation == OP_LOAD)
			acc = it.phase_value;
		acc = acc + step;
		e = acc[23:16];
		f = acc[15:8];
		c1 = tab[e];
		c2 = tab[e + 1];
		s1 = nsin_at(e, tab);
		s2 = nsin_at(e + 1, tab);
		// floor toward minus infinity via arithmetic shift
		r.cosine_out = 16'(c1 + ((f * (c2 - c1)) >>> 8));
		r.neg_sine_out = 16'(s1 + ((f * (s2 - s1)) >>> 8));
		pending.push_back(r);
	endfunction

	function void check_sample(nco_out_t got);
		nco_out_t want;
		if (pending.size() == 0) begin
			$error("unexpected sample %h", got);
			errors++;
			return;
		end
		want = pending.pop_front();
		if (got.neg_sine_out !== want.neg_sine_out) begin
			$error("neg_sine_out expected %0d actual %0d", want.neg_sine_out,
				got.neg_sine_out);
			errors++;
		end
		if (got.cosine_out !== want.cosine_out) begin
			$error("cosine_out expected %0d actual %0d", want.cosine_out,
				got.cosine_out);
			errors++;
		end
	endfunction
endclass

module tb_top;
	logic clk, arst_n;
	logic psel, penable, pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [31:0] pwdata, prdata;
	logic pready;
	logic in_valid, in_stall, out_valid, out_stall;
	nco_in_t in_data;
	nco_out_t out_data;

	sample_board board;
	int cos_tab[257];
	int src_idle, snk_idle;
	int hold_cycles;

	nco_interpolated_sincos DUT (.*);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("RESULT: ERROR");
		$finish;
	end

	// build the cosine table from the quarter-wave shape by symmetry
	task automatic fill_table();
		int q[65] = '{30000, 29990, 29963, 29918, 29855, 29774, 29675, 29558,
			29423, 29271, 29100, 28913, 28708, 28485, 28246, 27989, 27716, 27426,
			27119, 26796, 26457, 26102, 25731, 25345, 24944, 24527, 24096, 23650,
			23190, 22716, 22228, 21727, 21213, 20686, 20146, 19595, 19031, 18456,
			17870, 17274, 16667, 16049, 15423, 14786, 14141, 13488, 12826, 12157,
			11480, 10796, 10106, 9410, 8708, 8001, 7289, 6573, 5852, 5128, 4401,
			3672, 2940, 2206, 1472, 736, 0};
		for (int i = 0; i <= 64; i++) begin
			cos_tab[i] = q[i];
			cos_tab[128 - i] = -q[i];
			cos_tab[128 + i] = -q[i];
			cos_tab[(256 - i)] = q[i];
		end
		cos_tab[128] = -29999;
		cos_tab[64] = 0;
		cos_tab[192] = 0;
	endtask

	task automatic write_step(logic [23:0] v);
		@(posedge clk);
		psel <= 1;
		penable <= 0;
		pwrite <= 1;
		paddr <= REG_PHASE_INCREMENT;
		pwdata <= {8'h0, v};
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0;
		penable <= 0;
		pwrite <= 0;
		board.step = v;
	endtask

	task automatic drain();
		while (board.pending.size() != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic send_tick(logic op, logic [23:0] ph);
		while (src_idle != 0 && $urandom_range(99) < src_idle) begin
			in_valid <= 0;
			@(posedge clk);
		end
		in_valid <= 1;
		in_data <= '{operation: op, phase_value: ph};
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		board.note_tick('{operation: op, phase_value: ph}, cos_tab);
		in_valid <= 0;
	endtask

	// hold in_valid across back-to-back ticks: lower only when idling
	task automatic send_burst(int n);
		logic op;
		for (int i = 0; i < n; i++) begin
			op = ($urandom_range(3) == 0) ? OP_LOAD : OP_ADVANCE;
			if (src_idle != 0 && $urandom_range(99) < src_idle) begin
				in_valid <= 0;
				@(posedge clk);
				while ($urandom_range(99) < src_idle)
					@(posedge clk);
			end
			in_valid <= 1;
			in_data <= '{operation: op, phase_value: 24'($urandom)};
			@(posedge clk);
			while (in_stall)
				@(posedge clk);
			board.note_tick(in_data, cos_tab);
		end
		in_valid <= 0;
	endtask

	always @(posedge clk) begin
		if (out_valid && !out_stall)
			board.check_sample(out_data);
		if (hold_cycles > 0) begin
			out_stall <= 1;
			hold_cycles <= hold_cycles - 1;
		end else
			out_stall <= (snk_idle != 0) && ($urandom_range(99) < snk_idle);
	end

	initial begin
		logic [23:0] steps[6] = '{24'h0, 24'hFFFFFF, 24'h000100, 24'h800000,
			24'h012345, 24'h000001};
		board = new();
		fill_table();
		arst_n = 0;
		psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
		in_valid = 0; in_data = '0; out_stall = 0;
		src_idle = 0; snk_idle = 0; hold_cycles = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: extremes, loads, wrap, last entry, ignored phase value
		send_tick(OP_ADVANCE, 24'hFFFFFF);
		send_tick(OP_LOAD, 24'h000000);
		send_tick(OP_LOAD, 24'hFFFFFF);
		send_tick(OP_LOAD, 24'hFF8000);
		send_tick(OP_LOAD, 24'h3FFF00);
		drain();
		write_step(24'hFFFFFF);
		send_tick(OP_LOAD, 24'h000000);
		send_tick(OP_ADVANCE, 24'h123456);
		send_tick(OP_LOAD, 24'h555555);
		send_tick(OP_LOAD, 24'hAAAAAA);
		drain();
		write_step(24'h000080);
		send_tick(OP_LOAD, 24'hFFFF80);
		send_tick(OP_LOAD, 24'h7FFF80);
		send_tick(OP_LOAD, 24'hBF8080);
		send_tick(OP_ADVANCE, 24'h000000);
		drain();

		// long receiver hold with sender pushing, then sender pause
		write_step(24'h010203);
		hold_cycles <= 40;
		send_burst(20);
		drain();

		for (int ph = 0; ph < 6; ph++) begin
			if (ph < 2) begin src_idle = 30; snk_idle = 61; end
			else if (ph < 4) begin src_idle = 61; snk_idle = 30; end
			else begin src_idle = 0; snk_idle = 0; end
			write_step(ph == 5 ? 24'($urandom) : steps[ph]);
			send_burst(105);
			drain();
		end
		write_step(24'h0);

		if (board.errors == 0 && board.pending.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end
endmodule

// ===== files.f =====
design/nco_pkg.sv
design/nco_front.sv
design/nco_queue.sv
design/nco_back.sv
design/nco_interpolated_sincos.sv
test/tb_top.sv
